[rtl/hrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_pkg
// Widths, register indexes and reset values shared by the heart rate
// detector modules.
// ----------------------------------------------------------------------------
package hrd_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 20;
  localparam int FRAC_W     = 8;
  localparam int RATE_W     = 8;
  localparam int WEIGHT_W   = 9;
  localparam int INTERVAL_W = 16;
  localparam int DIV_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE = 9'd256;
  localparam logic [DIV_W-1:0]      RATE_NUM   = 16'd60000;
  localparam logic [DIV_W-1:0]      RATE_MAX   = 16'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT     = 3'd4;

  localparam logic [SAMPLE_W-1:0]   THRESHOLD_RST  = 12'd2050;
  localparam logic [SAMPLE_W-1:0]   HYSTERESIS_RST = 12'd100;
  localparam logic [INTERVAL_W-1:0] MIN_IVL_RST    = 16'd270;
  localparam logic [INTERVAL_W-1:0] MAX_IVL_RST    = 16'd1500;
  localparam logic [WEIGHT_W-1:0]   WEIGHT_RST     = 9'd77;

endpackage

[rtl/hrd_ewma.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_ewma
// Exponential smoothing filter in Q12.8, one weight bit per cycle:
// level = (w * (sample << 8) + (256 - w) * level) >> 8.
// ----------------------------------------------------------------------------
module hrd_ewma
  import hrd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [LEVEL_W-1:0]  level_in,
  output logic                done,
  output logic [LEVEL_W-1:0]  level_out
);

  localparam int ACC_W = LEVEL_W + WEIGHT_W + 1;
  localparam int HI_W  = ACC_W - WEIGHT_W + 1;
  localparam int CNT_W = $clog2(WEIGHT_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [WEIGHT_W-1:0] w_sr_r;
  logic [WEIGHT_W-1:0] wc_sr_r;
  logic [LEVEL_W-1:0]  a_r;
  logic [LEVEL_W-1:0]  b_r;
  logic [ACC_W-1:0]    acc_r;

  logic [WEIGHT_W-1:0] w_clamp;
  logic [HI_W-1:0]     hi_sum;
  logic [ACC_W-1:0]    acc_nxt;
  logic                last_step;

  assign w_clamp   = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
  assign hi_sum    = {1'b0, acc_r[ACC_W-1:WEIGHT_W]}
                   + (w_sr_r[0]  ? HI_W'(a_r) : HI_W'(0))
                   + (wc_sr_r[0] ? HI_W'(b_r) : HI_W'(0));
  assign acc_nxt   = {hi_sum, acc_r[WEIGHT_W-1:1]};
  assign last_step = (cnt_r == CNT_W'(WEIGHT_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w_sr_r  <= w_clamp;
      wc_sr_r <= WEIGHT_ONE - w_clamp;
      a_r     <= {sample, {FRAC_W{1'b0}}};
      b_r     <= level_in;
      acc_r   <= '0;
    end else if (busy_r) begin
      w_sr_r  <= w_sr_r >> 1;
      wc_sr_r <= wc_sr_r >> 1;
      acc_r   <= acc_nxt;
    end
  end

  assign done      = done_r;
  assign level_out = acc_r[LEVEL_W+FRAC_W-1:FRAC_W];

endmodule

[rtl/hrd_serial_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_serial_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrd_serial_div
  import hrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] q_r;
  logic [DIV_W:0]   rem_r;
  logic [DIV_W-1:0] d_r;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] diff;
  logic             last_step;

  assign rem_sh    = {rem_r[DIV_W-1:0], q_r[DIV_W-1]};
  assign diff      = {1'b0, rem_sh} - {2'b00, d_r};
  assign last_step = (cnt_r == CNT_W'(DIV_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[DIV_W+1]) begin
        rem_r <= diff[DIV_W:0];
        q_r   <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[rtl/ecg_heart_rate_detector.sv]
`timescale 1ns / 1ps
// A new sample is taken only in the idle state; in_stall stays high until the result
// of the last one is loaded into the output register. An ordinary sample passes the
// bit-serial filter, a counted beat adds two passes of the serial divider (rate, then
// average), and a sample with lead off skips the filter and goes straight to output.
// Reset (rst_n low, synchronous) loads the register defaults and clears the
// filter, beat state and rate ring at once; no clearing pass follows.
// ----------------------------------------------------------------------------
// ecg_heart_rate_detector
// ECG beat detector: smoothing filter, threshold with hysteresis, beat
// interval to BPM and a moving average over the last AVG_DEPTH beats.
// ----------------------------------------------------------------------------
module ecg_heart_rate_detector
  import hrd_pkg::*;
#(
  parameter int AVG_DEPTH = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  in_lead_off,
  input  logic [TIME_W-1:0]     in_time_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_W-1:0]    out_filtered_level,
  output logic [RATE_W-1:0]     out_average_rate,
  output logic                  out_beat_active,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_MAX = AVG_DEPTH * 255;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int POS_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FILT  = 6'b000010,
    ST_EVAL  = 6'b000100,
    ST_DRATE = 6'b001000,
    ST_DAVG  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0]   thr_r;
  logic [SAMPLE_W-1:0]   hyst_r;
  logic [INTERVAL_W-1:0] min_ivl_r;
  logic [INTERVAL_W-1:0] max_ivl_r;
  logic [WEIGHT_W-1:0]   weight_r;

  logic                  lead_off_r;
  logic [TIME_W-1:0]     time_r;

  logic [LEVEL_W-1:0]    smoothed_r, smoothed_nxt;
  logic [TIME_W-1:0]     prev_time_r, prev_time_nxt;
  logic                  awaiting_r, awaiting_nxt;
  logic                  in_beat_r, in_beat_nxt;
  logic [RATE_W-1:0]     ring_r [AVG_DEPTH];
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [RATE_W-1:0]     avg_r, avg_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]    out_level_r;
  logic [RATE_W-1:0]     out_rate_r;
  logic                  out_beat_r;

  logic                  in_xfer;
  logic                  out_load;
  logic                  ring_we;
  logic [RATE_W-1:0]     bpm;

  logic                  filt_start;
  logic                  filt_done;
  logic [LEVEL_W-1:0]    filt_level;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quot;

  logic [TIME_W-1:0]     interval;
  logic                  in_window;
  logic                  beat_hit;
  logic                  rearm_ok;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;

  assign interval  = time_r - prev_time_r;
  assign in_window = (interval > TIME_W'(min_ivl_r)) && (interval < TIME_W'(max_ivl_r));
  assign beat_hit  = (smoothed_r > {thr_r, {FRAC_W{1'b0}}}) && !in_beat_r;
  assign rearm_ok  = (hyst_r < thr_r) && (smoothed_r < {thr_r - hyst_r, {FRAC_W{1'b0}}});
  assign bpm       = (div_quot > RATE_MAX) ? RATE_MAX[RATE_W-1:0] : div_quot[RATE_W-1:0];

  // filter captures the sample on the transfer edge
  hrd_ewma u_ewma (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (filt_start),
    .weight    (weight_r),
    .sample    (in_sample),
    .level_in  (smoothed_r),
    .done      (filt_done),
    .level_out (filt_level)
  );

  hrd_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    smoothed_nxt  = smoothed_r;
    prev_time_nxt = prev_time_r;
    awaiting_nxt  = awaiting_r;
    in_beat_nxt   = in_beat_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    ring_we       = 1'b0;
    filt_start    = 1'b0;
    div_start     = 1'b0;
    div_dividend  = RATE_NUM;
    div_divisor   = interval[DIV_W-1:0];
    out_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = in_lead_off ? ST_OUT : ST_FILT;
        end
      end
      ST_FILT: begin
        if (filt_done) begin
          smoothed_nxt = filt_level;
          state_nxt    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_OUT;
        if (beat_hit) begin
          in_beat_nxt = 1'b1;
          if (awaiting_r) begin
            prev_time_nxt = time_r;
            awaiting_nxt  = 1'b0;
          end else if (in_window) begin
            div_start = 1'b1;
            state_nxt = ST_DRATE;
          end
        end else if (rearm_ok) begin
          in_beat_nxt = 1'b0;
        end
      end
      ST_DRATE: begin
        if (div_done) begin
          ring_we       = 1'b1;
          sum_nxt       = sum_r - SUM_W'(ring_r[pos_r]) + SUM_W'(bpm);
          pos_nxt       = (pos_r == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_r + 1'b1;
          prev_time_nxt = time_r;
          div_start     = 1'b1;
          div_dividend  = DIV_W'(sum_nxt);
          div_divisor   = DIV_W'(AVG_DEPTH);
          state_nxt     = ST_DAVG;
        end
      end
      ST_DAVG: begin
        if (div_done) begin
          avg_nxt   = div_quot[RATE_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (state_r == ST_IDLE && in_xfer && !in_lead_off) begin
      filt_start = 1'b1;
    end
    out_valid_nxt = (out_valid_r && out_stall) || out_load;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lead_off_r <= in_lead_off;
      time_r     <= in_time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THRESHOLD_RST;
      hyst_r      <= HYSTERESIS_RST;
      min_ivl_r   <= MIN_IVL_RST;
      max_ivl_r   <= MAX_IVL_RST;
      weight_r    <= WEIGHT_RST;
      smoothed_r  <= '0;
      prev_time_r <= '0;
      awaiting_r  <= 1'b1;
      in_beat_r   <= 1'b0;
      pos_r       <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      smoothed_r  <= smoothed_nxt;
      prev_time_r <= prev_time_nxt;
      awaiting_r  <= awaiting_nxt;
      in_beat_r   <= in_beat_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
      if (ring_we) begin
        ring_r[pos_r] <= bpm;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD:  thr_r     <= cfg_data[SAMPLE_W-1:0];
          CFG_HYSTERESIS: hyst_r    <= cfg_data[SAMPLE_W-1:0];
          CFG_MIN_IVL:    min_ivl_r <= cfg_data[INTERVAL_W-1:0];
          CFG_MAX_IVL:    max_ivl_r <= cfg_data[INTERVAL_W-1:0];
          CFG_WEIGHT:     weight_r  <= cfg_data[WEIGHT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (lead_off_r) begin
        out_level_r <= '0;
        out_rate_r  <= '0;
        out_beat_r  <= 1'b0;
      end else begin
        out_level_r <= smoothed_r;
        out_rate_r  <= avg_r;
        out_beat_r  <= in_beat_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_level = out_level_r;
  assign out_average_rate   = out_rate_r;
  assign out_beat_active    = out_beat_r;

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_W'(SUM_MAX))
    else $error("ring sum above depth times 255");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(AVG_DEPTH - 1))
    else $error("ring position out of range");

  a_lead_off_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_lead_off) |=> ($stable(smoothed_r) && $stable(in_beat_r)
                                  && $stable(sum_r) && $stable(prev_time_r)))
    else $error("lead-off sample changed detector state");

  a_lead_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && lead_off_r) |=> (out_valid && out_filtered_level == '0
                                  && out_average_rate == '0 && !out_beat_active))
    else $error("lead-off result not zero");

endmodule

[test/tb_ecg_heart_rate_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ecg_heart_rate_detector
// Self-checking bench for the ECG heart rate detector. A scoreboard class
// keeps its own model of the smoothing filter, beat detector and rate ring,
// predicts one result per input transfer and compares every output transfer
// field by field. Stimulus is a directed pass over wrap, window edges,
// saturation and weight/threshold extremes, then random phases of beat trains
// and noise under changing register settings, with random idle on both sides.
// ----------------------------------------------------------------------------
module tb_ecg_heart_rate_detector;
  import hrd_pkg::*;

  localparam int RING_DEPTH = 10;
  localparam int RANDOM_ITEMS = 1700;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_PRINTED = 100;
  localparam longint unsigned RUN_LIMIT_NS = 20_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_WEIGHT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [RATE_W-1:0]  rate;
    logic               beat;
  } hr_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample;
  logic                  in_lead_off;
  logic [TIME_W-1:0]     in_time_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic [LEVEL_W-1:0]    out_filtered_level;
  logic [RATE_W-1:0]     out_average_rate;
  logic                  out_beat_active;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit                    quiet;
  logic [TIME_W-1:0]     clock_ms;
  int unsigned           items_sent;

  class hr_scoreboard;
    logic [SAMPLE_W-1:0]   threshold;
    logic [SAMPLE_W-1:0]   hysteresis;
    logic [INTERVAL_W-1:0] min_ivl;
    logic [INTERVAL_W-1:0] max_ivl;
    logic [WEIGHT_W-1:0]   weight;
    logic [LEVEL_W-1:0]    level;
    logic [TIME_W-1:0]     last_beat_ms;
    bit                    first_beat_pending;
    bit                    in_beat;
    logic [RATE_W-1:0]     ring [RING_DEPTH];
    int unsigned           ring_pos;
    int unsigned           ring_sum;
    logic [RATE_W-1:0]     rate_avg;
    hr_result_t            expected [$];
    int unsigned           errors;
    int unsigned           results;

    function new();
      threshold = THRESHOLD_RST;
      hysteresis = HYSTERESIS_RST;
      min_ivl = MIN_IVL_RST;
      max_ivl = MAX_IVL_RST;
      weight = WEIGHT_RST;
      level = '0;
      last_beat_ms = '0;
      first_beat_pending = 1'b1;
      in_beat = 1'b0;
      foreach (ring[i]) ring[i] = '0;
      ring_pos = 0;
      ring_sum = 0;
      rate_avg = '0;
      errors = 0;
      results = 0;
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_THRESHOLD:  threshold = val[SAMPLE_W-1:0];
        CFG_HYSTERESIS: hysteresis = val[SAMPLE_W-1:0];
        CFG_MIN_IVL:    min_ivl = val[INTERVAL_W-1:0];
        CFG_MAX_IVL:    max_ivl = val[INTERVAL_W-1:0];
        CFG_WEIGHT:     weight = val[WEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [SAMPLE_W-1:0] s, logic lo, logic [TIME_W-1:0] t);
      hr_result_t         r;
      logic [WEIGHT_W-1:0] w;
      logic [63:0]        acc;
      logic [LEVEL_W-1:0] beat_level;
      logic [TIME_W-1:0]  ivl;
      int unsigned        bpm;
      r = '0;
      if (lo) begin
        expected.push_back(r);
        return;
      end
      w = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
      acc = 64'(w) * (64'(s) << FRAC_W) + 64'(WEIGHT_ONE - w) * 64'(level);
      level = acc[FRAC_W +: LEVEL_W];
      beat_level = LEVEL_W'(threshold) << FRAC_W;
      if (level > beat_level && !in_beat) begin
        if (first_beat_pending) begin
          last_beat_ms = t;
          first_beat_pending = 1'b0;
        end else begin
          ivl = t - last_beat_ms;
          if (ivl > min_ivl && ivl < max_ivl) begin
            bpm = RATE_NUM / ivl;
            if (bpm > RATE_MAX) bpm = RATE_MAX;
            ring_sum = ring_sum - ring[ring_pos] + bpm;
            ring[ring_pos] = RATE_W'(bpm);
            ring_pos = (ring_pos + 1) % RING_DEPTH;
            rate_avg = RATE_W'(ring_sum / RING_DEPTH);
            last_beat_ms = t;
          end
        end
        in_beat = 1'b1;
      end else if (hysteresis < threshold &&
                   level < (LEVEL_W'(threshold - hysteresis) << FRAC_W)) begin
        in_beat = 1'b0;
      end
      r.level = level;
      r.rate = rate_avg;
      r.beat = in_beat;
      expected.push_back(r);
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(hr_result_t got);
      hr_result_t want;
      results++;
      if (expected.size() == 0) begin
        report($sformatf("result %0d arrived with no sample pending", results));
        return;
      end
      want = expected.pop_front();
      if (got.level !== want.level)
        report($sformatf("result %0d filtered_level %0h, want %0h",
                         results, got.level, want.level));
      if (got.rate !== want.rate)
        report($sformatf("result %0d average_rate %0d, want %0d",
                         results, got.rate, want.rate));
      if (got.beat !== want.beat)
        report($sformatf("result %0d beat_active %0b, want %0b",
                         results, got.beat, want.beat));
    endtask

    task drain_check();
      if (expected.size() != 0)
        report($sformatf("%0d results never arrived", expected.size()));
    endtask
  endclass

  hr_scoreboard rate_sb = new();

  ecg_heart_rate_detector #(
    .AVG_DEPTH(RING_DEPTH)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_lead_off        (in_lead_off),
    .in_time_ms         (in_time_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_level (out_filtered_level),
    .out_average_rate   (out_average_rate),
    .out_beat_active    (out_beat_active),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_value(int unsigned ext_lo, int unsigned ext_hi,
                                             int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 11);
    if (r == 0) return ext_lo;
    if (r == 1) return ext_hi;
    return $urandom_range(lo, hi);
  endfunction

  // random bits above the register width, which the block must drop
  function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned v, int unsigned w);
    if (w < CFG_DATA_W && $urandom_range(0, 4) == 0)
      return CFG_DATA_W'(v) | (CFG_DATA_W'($urandom) << w);
    return CFG_DATA_W'(v);
  endfunction

  // output stall: short free runs broken by stalls, mostly short
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    out_stall = 1'b0;
    forever begin
      run_len = $urandom_range(1, 8);
      stall_len = idle_len();
      out_stall = 1'b0;
      repeat (run_len) @(negedge clk);
      if (stall_len != 0) begin
        out_stall = 1'b1;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    hr_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.level = out_filtered_level;
      got.rate = out_average_rate;
      got.beat = out_beat_active;
      rate_sb.check_result(got);
    end
  end

  task automatic send(input logic [SAMPLE_W-1:0] s, input logic lo,
                      input logic [TIME_W-1:0] dt);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    clock_ms = clock_ms + dt;
    in_valid = 1'b1;
    in_sample = s;
    in_lead_off = lo;
    in_time_ms = clock_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rate_sb.note_input(s, lo, clock_ms);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (rate_sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    rate_sb.apply_config(idx, val);
  endtask

  task automatic randomize_config();
    int unsigned w;
    write_reg(CFG_THRESHOLD, with_junk(pick_value(0, 4095, 1200, 3200), SAMPLE_W));
    write_reg(CFG_HYSTERESIS, with_junk(pick_value(0, 4095, 0, 900), SAMPLE_W));
    write_reg(CFG_MIN_IVL, CFG_DATA_W'(pick_value(1, 65535, 100, 400)));
    write_reg(CFG_MAX_IVL, CFG_DATA_W'(pick_value(1, 65535, 800, 2500)));
    if ($urandom_range(0, 9) == 0) w = $urandom_range(257, 511);
    else w = pick_value(0, 256, 40, 256);
    write_reg(CFG_WEIGHT, with_junk(w, WEIGHT_W));
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)),
                CFG_DATA_W'($urandom));
  endtask

  task automatic beat_train(input int unsigned beats);
    int unsigned ivl;
    int unsigned n_hi;
    int unsigned n_lo;
    int unsigned step;
    int unsigned r;
    logic [TIME_W-1:0] dt;
    repeat (beats) begin
      if ($urandom_range(0, 7) == 0) ivl = $urandom_range(1, 240);
      else ivl = $urandom_range(150, 2200);
      n_hi = $urandom_range(2, 6);
      n_lo = $urandom_range(2, 8);
      step = ivl / (n_hi + n_lo);
      for (int k = 0; k < n_hi + n_lo; k++) begin
        dt = (k == 0) ? ivl - step * (n_hi + n_lo - 1) : step;
        r = $urandom_range(0, 99);
        if (r < 4) send(SAMPLE_W'($urandom), 1'b1, dt);
        else if (r < 7) send(SAMPLE_W'($urandom), 1'b0, dt);
        else if (k < n_hi) send(SAMPLE_W'($urandom_range(2800, 4095)), 1'b0, dt);
        else send(SAMPLE_W'($urandom_range(0, 1400)), 1'b0, dt);
      end
    end
  endtask

  task automatic noise_burst(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0)
        send(SAMPLE_W'($urandom), 1'($urandom), TIME_W'($urandom));
      else
        send(SAMPLE_W'($urandom), 1'($urandom), TIME_W'($urandom_range(0, 50)));
    end
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_ecg_heart_rate_detector NOT OK");
    $finish;
  end

  initial begin
    int unsigned start_count;
    in_valid = 1'b0;
    in_sample = '0;
    in_lead_off = 1'b0;
    in_time_ms = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    quiet = 1'b0;
    clock_ms = '0;
    items_sent = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // default settings: lead off, then a first beat just before the time wrap
    // and a counted beat after it, one sample landing on time zero
    clock_ms = 32'hFFFF_FFFE;
    send(12'hFFF, 1'b1, 1);
    clock_ms = 32'hFFFF_FD00;
    send(12'h000, 1'b0, 0);
    repeat (4) send(12'hFFF, 1'b0, 4);
    repeat (4) send(12'h000, 1'b0, 100);
    send(12'hFFF, 1'b0, 32'h160);
    repeat (2) send(12'hFFF, 1'b0, 100);

    // interval window edges at full weight
    settle();
    write_reg(CFG_THRESHOLD, 16'd2000);
    write_reg(CFG_HYSTERESIS, 16'd100);
    write_reg(CFG_MIN_IVL, 16'd300);
    write_reg(CFG_MAX_IVL, 16'd1000);
    write_reg(CFG_WEIGHT, 16'd256);
    send(12'h000, 1'b0, 10);
    send(12'hFFF, 1'b0, 390);
    send(12'h000, 1'b0, 150);
    send(12'hFFF, 1'b0, 150);
    send(12'h000, 1'b0, 0);
    send(12'hFFF, 1'b0, 1);
    send(12'h000, 1'b0, 500);
    send(12'hFFF, 1'b0, 499);
    send(12'h000, 1'b0, 500);
    send(12'hFFF, 1'b0, 500);

    // rate saturation with the widest window
    settle();
    write_reg(CFG_MIN_IVL, 16'd1);
    write_reg(CFG_MAX_IVL, 16'hFFFF);
    send(12'h000, 1'b0, 0);
    send(12'hFFF, 1'b0, 2);
    send(12'h000, 1'b0, 0);
    send(12'hFFF, 1'b0, 2);

    // hysteresis equal to threshold never rearms; weight above full scale
    settle();
    write_reg(CFG_HYSTERESIS, 16'd2000);
    write_reg(CFG_WEIGHT, 16'd511);
    send(12'h000, 1'b0, 5);
    send(12'hFFF, 1'b0, 5);

    // threshold at both ends, frozen and minimal weight
    settle();
    write_reg(CFG_THRESHOLD, 16'd4095);
    write_reg(CFG_HYSTERESIS, 16'd0);
    write_reg(CFG_WEIGHT, 16'd256);
    send(12'hFFF, 1'b0, 5);
    send(12'h000, 1'b0, 5);
    settle();
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_WEIGHT, 16'd0);
    write_reg(CFG_LAST_INDEX, 16'hFFFF);
    send(12'hFFF, 1'b0, 5);
    settle();
    write_reg(CFG_WEIGHT, 16'd1);
    send(12'hFFF, 1'b0, 5);
    send(12'h000, 1'b1, 5);

    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      settle();
      quiet = ($urandom_range(0, 4) == 0);
      randomize_config();
      if ($urandom_range(0, 7) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4000);
      if ($urandom_range(0, 9) < 8) beat_train($urandom_range(8, 20));
      else noise_burst($urandom_range(15, 40));
    end

    quiet = 1'b0;
    settle();
    rate_sb.drain_check();
    if (rate_sb.errors == 0) begin
      $display("tb_ecg_heart_rate_detector OK");
    end else begin
      $display("tb_ecg_heart_rate_detector NOT OK");
    end
    $finish;
  end

endmodule

[ecg_heart_rate_detector.f]
rtl/hrd_pkg.sv
rtl/hrd_ewma.sv
rtl/hrd_serial_div.sv
rtl/ecg_heart_rate_detector.sv
test/tb_ecg_heart_rate_detector.sv
